### rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// clk and rst_n must be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define MET_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression never true at a clock edge outside reset
`define MET_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/core/met_pkg.sv
package met_pkg;

    // coordinate format, signed fixed point
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 28;

    localparam int PROD_WIDTH = 2 * COORD_WIDTH;
    localparam int ACC_WIDTH  = 4 * COORD_WIDTH;

    localparam int ITER_WIDTH = 16;
    localparam int LEN_WIDTH  = ITER_WIDTH + 1;

    // configuration registers
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_MAX_ITER = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_MIN_ITER = 1'd1;
    localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET = 16'd105;
    localparam logic [ITER_WIDTH-1:0] MIN_ITER_RESET = 16'd100;

    // multiplier operand selection, each op has a fixed product register
    typedef logic [3:0] mul_op_t;
    localparam mul_op_t MUL_NONE = 4'd0;
    localparam mul_op_t MUL_RR   = 4'd1;
    localparam mul_op_t MUL_II   = 4'd2;
    localparam mul_op_t MUL_RI   = 4'd3;
    localparam mul_op_t MUL_XB   = 4'd4;
    localparam mul_op_t MUL_YY   = 4'd5;
    localparam mul_op_t MUL_UU   = 4'd6;
    localparam mul_op_t MUL_QLSL = 4'd7;
    localparam mul_op_t MUL_QLSH = 4'd8;
    localparam mul_op_t MUL_QHSL = 4'd9;
    localparam mul_op_t MUL_QHSH = 4'd10;

    // accumulator operations for the cardioid product
    typedef logic [1:0] acc_op_t;
    localparam acc_op_t ACC_NONE = 2'd0;
    localparam acc_op_t ACC_LOAD = 2'd1;
    localparam acc_op_t ACC_ADD1 = 2'd2;
    localparam acc_op_t ACC_ADD2 = 2'd3;

    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        logic    zr_upd;
        logic    zi_upd;
        logic    len_inc;
        logic    q_load;
        logic    s_load;
        acc_op_t acc_op;
        logic    rgn_we;
        logic    rgn_val;
    } met_cmd_t;

    typedef struct packed {
        logic len_gt_max;
        logic escaped;
        logic far;
        logic bulb_in;
        logic u_neg;
        logic q_lt_t;
        logic card_in;
    } met_status_t;

endpackage

### rtl/core/met_datapath.sv
module met_datapath
    import met_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [ITER_WIDTH-1:0]         cfg_wdata,
    input  logic signed [COORD_WIDTH-1:0] c_real,
    input  logic signed [COORD_WIDTH-1:0] c_imag,
    input  met_cmd_t                      cmd,
    output met_status_t                   status,
    output logic [LEN_WIDTH-1:0]          orbit_length,
    output logic                          in_main_set_region,
    output logic                          selected
);

    localparam int W  = COORD_WIDTH;
    localparam int ZW = PROD_WIDTH + 2;
    localparam int LW = ACC_WIDTH + 2;

    localparam logic [W-1:0] ONE_C = W'(1) << FRAC_BITS;
    localparam logic [W-1:0] TWO_C = W'(1) << (FRAC_BITS + 1);
    localparam logic [W:0] ONE_X = (W+1)'(1) << FRAC_BITS;
    localparam logic [W:0] QUARTER_X = ONE_X >> 2;
    localparam logic [PROD_WIDTH:0] ESC_LIMIT  = (PROD_WIDTH+1)'(1) << (2 * FRAC_BITS + 2);
    localparam logic [PROD_WIDTH:0] BULB_LIMIT = (PROD_WIDTH+1)'(1) << (2 * FRAC_BITS - 4);

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + W'(1)) : v;
    endfunction

    // magnitude of a one-bit-wider value, low W bits
    function automatic logic [W-1:0] mag_wide(input logic [W:0] v);
        logic [W:0] m;
        m = v[W] ? (~v + (W+1)'(1)) : v;
        return m[W-1:0];
    endfunction

    logic [ITER_WIDTH-1:0] max_iter_reg;
    logic [ITER_WIDTH-1:0] min_iter_reg;
    logic [LEN_WIDTH-1:0]  len_reg;
    logic                  region_reg;

    logic signed [W-1:0] cr_reg;
    logic signed [W-1:0] ci_reg;
    logic signed [W-1:0] zr_reg;
    logic signed [W-1:0] zi_reg;
    logic [PROD_WIDTH-1:0] p0_reg;
    logic [PROD_WIDTH-1:0] p1_reg;
    logic [PROD_WIDTH-1:0] p2_reg;
    logic                  xy_neg_reg;
    logic [PROD_WIDTH-1:0] q_reg;
    logic [PROD_WIDTH-1:0] s_reg;
    logic [ACC_WIDTH-1:0]  acc_reg;

    logic [W-1:0] zr_mag, zi_mag, cr_mag, ci_mag, xb_mag, u_mag;
    logic [W:0]   xb_wide, u_wide;
    logic [W-1:0] mul_a, mul_b;
    logic [PROD_WIDTH-1:0] mul_p;
    logic [PROD_WIDTH:0]   sq_sum;
    logic [PROD_WIDTH-1:0] t_val;
    logic [ZW-1:0] xx, yy, xy, xy_s, cr_ext, ci_ext, zr_sum, zi_sum;
    logic [LW-1:0] card_lhs, card_rhs;

    assign zr_mag = mag_of(zr_reg);
    assign zi_mag = mag_of(zi_reg);
    assign cr_mag = mag_of(cr_reg);
    assign ci_mag = mag_of(ci_reg);

    // shifted points for the bulb and cardioid tests
    assign xb_wide = {cr_reg[W-1], cr_reg} + ONE_X;
    assign u_wide  = {cr_reg[W-1], cr_reg} - QUARTER_X;
    assign xb_mag  = mag_wide(xb_wide);
    assign u_mag   = mag_wide(u_wide);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_RR:   begin mul_a = zr_mag;            mul_b = zr_mag;            end
            MUL_II:   begin mul_a = zi_mag;            mul_b = zi_mag;            end
            MUL_RI:   begin mul_a = zr_mag;            mul_b = zi_mag;            end
            MUL_XB:   begin mul_a = xb_mag;            mul_b = xb_mag;            end
            MUL_YY:   begin mul_a = ci_mag;            mul_b = ci_mag;            end
            MUL_UU:   begin mul_a = u_mag;             mul_b = u_mag;             end
            MUL_QLSL: begin mul_a = q_reg[W-1:0];      mul_b = s_reg[W-1:0];      end
            MUL_QLSH: begin mul_a = q_reg[W-1:0];      mul_b = s_reg[2*W-1:W];    end
            MUL_QHSL: begin mul_a = q_reg[2*W-1:W];    mul_b = s_reg[W-1:0];      end
            MUL_QHSH: begin mul_a = q_reg[2*W-1:W];    mul_b = s_reg[2*W-1:W];    end
            default:  begin mul_a = '0;                mul_b = '0;                end
        endcase
    end

    assign mul_p = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

    // exact sum of the two squares
    assign sq_sum = {1'b0, p0_reg} + {1'b0, p1_reg};
    assign t_val  = PROD_WIDTH'(u_mag) << FRAC_BITS;

    // next orbit point from the registered products
    assign xx     = {2'b00, p0_reg >> FRAC_BITS};
    assign yy     = {2'b00, p1_reg >> FRAC_BITS};
    assign xy     = {2'b00, p2_reg >> FRAC_BITS};
    assign xy_s   = xy_neg_reg ? (~xy + ZW'(1)) : xy;
    assign cr_ext = {{(ZW-W){cr_reg[W-1]}}, cr_reg};
    assign ci_ext = {{(ZW-W){ci_reg[W-1]}}, ci_reg};
    assign zr_sum = xx - yy + cr_ext;
    assign zi_sum = (xy_s << 1) + ci_ext;

    assign card_lhs = {acc_reg, 2'b00};
    assign card_rhs = LW'(p1_reg) << (2 * FRAC_BITS);

    always_comb
    begin
        status.len_gt_max = len_reg > LEN_WIDTH'(max_iter_reg);
        status.escaped    = sq_sum > ESC_LIMIT;
        status.far        = (cr_mag > TWO_C) || (ci_mag > ONE_C);
        status.bulb_in    = sq_sum < BULB_LIMIT;
        status.u_neg      = u_wide[W];
        status.q_lt_t     = q_reg < t_val;
        status.card_in    = card_lhs < card_rhs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RESET;
            min_iter_reg <= MIN_ITER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDX_MAX_ITER: max_iter_reg <= cfg_wdata;
                CFG_IDX_MIN_ITER: min_iter_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= LEN_WIDTH'(1);
            region_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                len_reg    <= LEN_WIDTH'(1);
                region_reg <= 1'b0;
            end
            else
            begin
                if (cmd.len_inc)
                    len_reg <= len_reg + LEN_WIDTH'(1);
                if (cmd.rgn_we)
                    region_reg <= cmd.rgn_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg <= c_real;
            ci_reg <= c_imag;
            zr_reg <= c_real;
            zi_reg <= c_imag;
        end
        else
        begin
            if (cmd.zr_upd)
                zr_reg <= zr_sum[W-1:0];
            if (cmd.zi_upd)
                zi_reg <= zi_sum[W-1:0];
        end

        case (cmd.mul_op) inside
            MUL_RR, MUL_XB, MUL_UU: p0_reg <= mul_p;
            MUL_II, MUL_YY:         p1_reg <= mul_p;
            MUL_RI, MUL_QLSL, MUL_QLSH, MUL_QHSL, MUL_QHSH:
                                    p2_reg <= mul_p;
            default: ;
        endcase

        if (cmd.mul_op == MUL_RI)
            xy_neg_reg <= zr_reg[W-1] ^ zi_reg[W-1];

        if (cmd.q_load)
            q_reg <= sq_sum[PROD_WIDTH-1:0];
        if (cmd.s_load)
            s_reg <= status.u_neg ? (q_reg - t_val) : (q_reg + t_val);

        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= ACC_WIDTH'(p2_reg);
            ACC_ADD1: acc_reg <= acc_reg + (ACC_WIDTH'(p2_reg) << W);
            ACC_ADD2: acc_reg <= acc_reg + (ACC_WIDTH'(p2_reg) << (2 * W));
            default: ;
        endcase
    end

    assign orbit_length       = len_reg;
    assign in_main_set_region = region_reg;
    assign selected = (len_reg > LEN_WIDTH'(min_iter_reg)) &&
                      (len_reg < LEN_WIDTH'(max_iter_reg)) && !region_reg;

endmodule

### rtl/core/met_controller.sv
module met_controller
    import met_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  met_status_t status,
    output met_cmd_t    cmd,
    output logic        busy,
    output logic        done
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MRR  = 5'd1;
    localparam logic [4:0] S_MII  = 5'd2;
    localparam logic [4:0] S_MRI  = 5'd3;
    localparam logic [4:0] S_UPD  = 5'd4;
    localparam logic [4:0] S_R0   = 5'd5;
    localparam logic [4:0] S_R1   = 5'd6;
    localparam logic [4:0] S_R2   = 5'd7;
    localparam logic [4:0] S_R3   = 5'd8;
    localparam logic [4:0] S_R4   = 5'd9;
    localparam logic [4:0] S_R5   = 5'd10;
    localparam logic [4:0] S_R6   = 5'd11;
    localparam logic [4:0] S_R7   = 5'd12;
    localparam logic [4:0] S_R8   = 5'd13;
    localparam logic [4:0] S_R9   = 5'd14;
    localparam logic [4:0] S_R10  = 5'd15;
    localparam logic [4:0] S_DONE = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_NONE;
        cmd.acc_op = ACC_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MRR;
                end
            end
            S_MRR:
            begin
                cmd.mul_op = MUL_RR;
                state_next = status.len_gt_max ? S_R0 : S_MII;
            end
            S_MII:
            begin
                cmd.mul_op = MUL_II;
                state_next = S_MRI;
            end
            S_MRI:
            begin
                cmd.mul_op = MUL_RI;
                if (status.escaped)
                    state_next = S_R0;
                else
                begin
                    cmd.zr_upd  = 1'b1;
                    cmd.len_inc = 1'b1;
                    state_next  = S_UPD;
                end
            end
            S_UPD:
            begin
                // imaginary part lands while the new real part is squared
                cmd.zi_upd = 1'b1;
                cmd.mul_op = MUL_RR;
                state_next = status.len_gt_max ? S_R0 : S_MII;
            end
            S_R0:
            begin
                if (status.far)
                begin
                    cmd.rgn_we  = 1'b1;
                    cmd.rgn_val = 1'b0;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.mul_op = MUL_XB;
                    state_next = S_R1;
                end
            end
            S_R1:
            begin
                cmd.mul_op = MUL_YY;
                state_next = S_R2;
            end
            S_R2:
            begin
                if (status.bulb_in)
                begin
                    cmd.rgn_we  = 1'b1;
                    cmd.rgn_val = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.mul_op = MUL_UU;
                    state_next = S_R3;
                end
            end
            S_R3:
            begin
                cmd.q_load = 1'b1;
                state_next = S_R4;
            end
            S_R4:
            begin
                if (status.u_neg && status.q_lt_t)
                begin
                    cmd.rgn_we  = 1'b1;
                    cmd.rgn_val = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.s_load = 1'b1;
                    state_next = S_R5;
                end
            end
            S_R5:
            begin
                cmd.mul_op = MUL_QLSL;
                state_next = S_R6;
            end
            S_R6:
            begin
                cmd.acc_op = ACC_LOAD;
                cmd.mul_op = MUL_QLSH;
                state_next = S_R7;
            end
            S_R7:
            begin
                cmd.acc_op = ACC_ADD1;
                cmd.mul_op = MUL_QHSL;
                state_next = S_R8;
            end
            S_R8:
            begin
                cmd.acc_op = ACC_ADD1;
                cmd.mul_op = MUL_QHSH;
                state_next = S_R9;
            end
            S_R9:
            begin
                cmd.acc_op = ACC_ADD2;
                state_next = S_R10;
            end
            S_R10:
            begin
                cmd.rgn_we  = 1'b1;
                cmd.rgn_val = status.card_in;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/mandelbrot_escape_time_unit.sv
// escape-time unit for one complex point c = c_real + i*c_imag, signed Q4.28
// input: a point is taken at a clock edge with start high and busy low;
//   busy stays high from the next cycle until the result beat has gone out
// output: done is high for exactly one cycle; orbit_length, in_main_set_region
//   and selected are valid in that cycle; the receiver cannot stall, so the
//   beat is simply taken at the edge that ends it
// config: cfg_we with cfg_index 0 (max_iterations) or 1 (min_iterations) and
//   cfg_wdata, written at the edge; the user writes only while busy is low;
//   the unit itself does not enforce it
// orbit loop: one shared 32x32 multiplier, three products per iteration
//   (re*re, im*im, re*im)
// the region test follows on the same multiplier: far points need no product,
//   the bulb two, the cardioid u*u and 4 limb products of q*s
// one point at a time, the next may be started the cycle after done
// reset: asynchronous, active low; controller idle, registers back to
//   max_iterations 105 and min_iterations 100
module mandelbrot_escape_time_unit
    import met_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] c_real,
    input  logic signed [COORD_WIDTH-1:0] c_imag,
    output logic                          done,
    output logic [LEN_WIDTH-1:0]          orbit_length,
    output logic                          in_main_set_region,
    output logic                          selected,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [ITER_WIDTH-1:0]         cfg_wdata
);

    // command and status between sequencer and datapath
    met_cmd_t    cmd;
    met_status_t status;

    // sequencer: orbit loop, then far, bulb and cardioid checks
    met_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // datapath: config registers, shared multiplier, orbit and region state
    met_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .c_real             (c_real),
        .c_imag             (c_imag),
        .cmd                (cmd),
        .status             (status),
        .orbit_length       (orbit_length),
        .in_main_set_region (in_main_set_region),
        .selected           (selected)
    );

endmodule

### rtl/core/met_checker.sv
`include "assert_macros.svh"

module met_checker
    import met_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [LEN_WIDTH-1:0] orbit_length,
    input logic                 in_main_set_region,
    input logic                 selected
);

    // result beat only while a point is in flight
    `MET_ASSERT(a_done_in_busy, done |-> busy, "result beat outside busy window")
    // unit goes idle right after the result beat
    `MET_ASSERT(a_idle_after_done, done |=> !busy, "busy held after result beat")
    // an accepted point never finishes in the next cycle
    `MET_ASSERT(a_accept_latency, (start && !busy) |=> (busy && !done), "point not held")
    // a point inside the known regions is never selected
    `MET_NEVER(a_sel_region, done && selected && in_main_set_region, "region point selected")
    // orbit length is at least one
    `MET_NEVER(a_len_nonzero, done && (orbit_length == '0), "zero orbit length")

endmodule

bind mandelbrot_escape_time_unit met_checker u_met_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .done               (done),
    .orbit_length       (orbit_length),
    .in_main_set_region (in_main_set_region),
    .selected           (selected)
);
